[design/zerl_pkg.sv]
// shared types and constants for the zip end record locator
// no dependencies; imported by every module of the block

package zerl_pkg;

    localparam int REC_LEN      = 22;
    localparam int SIG_LEN      = 4;
    localparam int COMMENT_AT   = 20;
    localparam int SEARCH_REACH = 22 + 65535;
    localparam int ADDR_W       = 3;

    localparam logic [31:0] EOCD_SIGNATURE = 32'h0605_4b50;

    // register select, taken from paddr[2]
    localparam logic REG_START = 1'b0;
    localparam logic REG_STOP  = 1'b1;

    typedef logic [7:0] byte_t;

    // archive region settings, pre-digested at write time
    typedef struct packed {
        logic [31:0] stop;
        logic [31:0] limit;      // stop - record length
        logic        limit_ok;   // stop holds at least one record
        logic [31:0] floor;      // lowest candidate offset allowed
        logic        region_ok;  // stop >= start and span holds a record
    } region_cfg_t;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic [15:0] comment;
    } locate_result_t;

endpackage

[design/zerl_cell.sv]
// one byte cell of the record window chain
// uses zerl_pkg for the byte type

module zerl_cell
    import zerl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  logic  clear,
    input  byte_t din,
    output byte_t dout
);

    byte_t byte_reg;
    byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (shift)
        begin
            byte_next = clear ? '0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

[design/zerl_match.sv]
// candidate check, position count and best-match tracking
// uses zerl_pkg for region settings and the result type

module zerl_match
    import zerl_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           last,
    input  logic [31:0]    sig_bytes,
    input  logic [15:0]    comment,
    input  region_cfg_t    cfg,
    output locate_result_t result
);

    localparam int CW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] cand_reg;
    logic [OFFSET_BITS-1:0] cand_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [OFFSET_BITS-1:0] off_next;
    logic [15:0]            cmt_reg;
    logic [15:0]            cmt_next;

    logic          full;
    logic          at_top;
    logic          hit;
    logic [CW-1:0] cand_w;
    logic [CW-1:0] limit_w;
    logic [CW-1:0] floor_w;
    logic [CW-1:0] stop_w;
    logic [CW-1:0] size_w;
    logic [CW-1:0] reach_w;
    logic [CW-1:0] off_w;
    logic          ok;

    assign full   = (pos_reg >= OFFSET_BITS'(REC_LEN - 1));
    assign at_top = &pos_reg;

    assign cand_w  = CW'(cand_reg);
    assign limit_w = CW'(cfg.limit);
    assign floor_w = CW'(cfg.floor);
    assign stop_w  = CW'(cfg.stop);
    assign size_w  = CW'(pos_reg) + CW'(1);
    assign reach_w = cand_w + CW'(comment);

    // comment must run exactly to the stop offset: cand + 22 + comment == stop
    assign hit = full && (sig_bytes == EOCD_SIGNATURE) && cfg.limit_ok
                 && (cand_w <= limit_w) && (cand_w >= floor_w)
                 && (reach_w == limit_w);

    always_comb
    begin
        pos_next  = pos_reg;
        cand_next = cand_reg;
        seen_next = seen_reg;
        off_next  = off_reg;
        cmt_next  = cmt_reg;
        if (step)
        begin
            if (hit)
            begin
                seen_next = 1'b1;
                off_next  = cand_reg;
                cmt_next  = comment;
            end
            if (!at_top)
            begin
                pos_next = pos_reg + OFFSET_BITS'(1);
                if (full)
                begin
                    cand_next = cand_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    // result of the beat that closes the buffer, taken before the clear
    assign ok     = cfg.region_ok && !(stop_w > size_w) && seen_next;
    assign off_w  = CW'(off_next);

    always_comb
    begin
        result.found   = ok;
        result.offset  = ok ? off_w[31:0] : '0;
        result.comment = ok ? cmt_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cand_reg <= '0;
            seen_reg <= 1'b0;
            off_reg  <= '0;
            cmt_reg  <= '0;
        end
        else if (step && last)
        begin
            pos_reg  <= '0;
            cand_reg <= '0;
            seen_reg <= 1'b0;
            off_reg  <= '0;
            cmt_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            cand_reg <= cand_next;
            seen_reg <= seen_next;
            off_reg  <= off_next;
            cmt_reg  <= cmt_next;
        end
    end

endmodule

[design/zip_end_record_locator_core.sv]
// zip end record locator: streams buffer bytes through a 22-cell window chain
// and reports the end-of-central-directory record in the archive region
// latency: result beat is valid the cycle after the last byte's beat is taken
// throughput: one byte per cycle; the only hold-off is a last byte while an
// earlier result is still stalled in the output register
// reset: rst_n clears window, counters, match state and both region registers

module zip_end_record_locator_core
    import zerl_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              record_found,
    output logic [31:0]       record_offset,
    output logic [15:0]       comment_bytes
);

    localparam logic [31:0] REC_LEN_W = 32'(REC_LEN);
    localparam logic [31:0] REACH_W   = 32'(SEARCH_REACH);

    logic [31:0]    start_reg;
    logic [31:0]    start_next;
    logic [31:0]    stop_reg;
    logic [31:0]    stop_next;
    region_cfg_t    cfg_reg;
    region_cfg_t    cfg_next;
    logic           wr;
    logic [31:0]    reach_floor;

    logic           in_take;
    byte_t          win [REC_LEN];
    locate_result_t res;

    logic           out_valid_reg;
    logic           out_valid_next;
    locate_result_t res_reg;

    // register port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        start_next = start_reg;
        stop_next  = stop_reg;
        if (wr)
        begin
            case (paddr[2])
                REG_START: start_next = pwdata;
                REG_STOP:  stop_next  = pwdata;
                default:   start_next = start_reg;
            endcase
        end
    end

    always_comb
    begin
        reach_floor        = (stop_next > REACH_W) ? (stop_next - REACH_W) : '0;
        cfg_next.stop      = stop_next;
        cfg_next.limit     = stop_next - REC_LEN_W;
        cfg_next.limit_ok  = (stop_next >= REC_LEN_W);
        cfg_next.floor     = (start_next > reach_floor) ? start_next : reach_floor;
        cfg_next.region_ok = (stop_next >= start_next)
                             && ((stop_next - start_next) >= REC_LEN_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            stop_reg  <= '0;
            cfg_reg   <= '{stop: '0, limit: '0, limit_ok: 1'b0, floor: '0,
                           region_ok: 1'b0};
        end
        else if (wr)
        begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
            cfg_reg   <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START: prdata = start_reg;
            REG_STOP:  prdata = stop_reg;
            default:   prdata = '0;
        endcase
    end

    // only a closing beat needs the output register
    assign in_stall = final_byte && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // window chain, oldest byte in cell 0
    for (genvar i = 0; i < REC_LEN; i++)
    begin : g_cell
        byte_t din;
        if (i == REC_LEN - 1)
        begin : g_tail
            assign din = data_byte;
        end
        else
        begin : g_body
            assign din = win[i+1];
        end
        zerl_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (in_take),
            .clear (final_byte),
            .din   (din),
            .dout  (win[i])
        );
    end

    // window as it stands once this beat has shifted in
    zerl_match #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_take),
        .last      (final_byte),
        .sig_bytes ({win[SIG_LEN], win[3], win[2], win[1]}),
        .comment   ({data_byte, win[COMMENT_AT + 1]}),
        .cfg       (cfg_reg),
        .result    (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_take && final_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && final_byte)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_found  = res_reg.found;
    assign record_offset = res_reg.offset;
    assign comment_bytes = res_reg.comment;

endmodule

[tb/zerl_checker.sv]
// beat watcher and result predictor for the zip end record locator
// depends on zerl_pkg; sits beside the core and hands back error and pending counts

module zerl_checker
    import zerl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              record_found,
    input  logic [31:0]       record_offset,
    input  logic [15:0]       comment_bytes,
    output int                mismatches,
    output int                outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned POSITION_TOP = 64'hFFFF_FFFF;

    logic [31:0]    region_start;
    logic [31:0]    region_stop;
    byte_t          window [REC_LEN];
    logic [31:0]    position;
    logic           seen;
    logic [31:0]    hit_offset;
    logic [15:0]    hit_comment;
    locate_result_t predicted_records [$];
    int             error_total = 0;

    assign mismatches = error_total;

    function automatic void clear_stream();
        foreach (window[i])
            window[i] = '0;
        position    = '0;
        seen        = 1'b0;
        hit_offset  = '0;
        hit_comment = '0;
    endfunction

    task automatic shift_in_byte(input byte_t value, input logic last);
        longint unsigned cur;
        longint unsigned cand;
        longint unsigned stop;
        longint unsigned start;
        longint unsigned reach_floor;
        longint unsigned lowest;
        logic [31:0]     sig;
        logic [15:0]     comment;
        locate_result_t  res;

        cur   = position;
        stop  = region_stop;
        start = region_start;
        for (int i = 0; i < REC_LEN - 1; i++)
            window[i] = window[i + 1];
        window[REC_LEN - 1] = value;

        // candidate record starts at the oldest byte of a full window
        if (cur >= REC_LEN - 1)
        begin
            cand        = cur - (REC_LEN - 1);
            sig         = {window[3], window[2], window[1], window[0]};
            comment     = {window[COMMENT_AT + 1], window[COMMENT_AT]};
            reach_floor = (stop > SEARCH_REACH) ? stop - SEARCH_REACH : 0;
            lowest      = (start > reach_floor) ? start : reach_floor;
            if (sig == EOCD_SIGNATURE && stop >= REC_LEN && cand <= stop - REC_LEN &&
                cand >= lowest && comment == stop - cand - REC_LEN)
            begin
                seen        = 1'b1;
                hit_offset  = cand[31:0];
                hit_comment = comment;
            end
        end

        if (cur < POSITION_TOP)
            position = cur + 1;

        if (last)
        begin
            res = '0;
            // region must fit in the buffer and hold at least one record
            if (seen && stop <= cur + 1 && stop >= start && stop - start >= REC_LEN)
            begin
                res.found   = 1'b1;
                res.offset  = hit_offset;
                res.comment = hit_comment;
            end
            predicted_records.push_back(res);
            clear_stream();
        end
    endtask

    task automatic check_result();
        locate_result_t want;

        if (predicted_records.size() == 0)
        begin
            $error("result beat with nothing expected: found %0b offset %0h comment %0h",
                   record_found, record_offset, comment_bytes);
            error_total++;
        end
        else
        begin
            want = predicted_records.pop_front();
            if (record_found !== want.found)
            begin
                $error("record_found mismatch: expected %0b, got %0b", want.found,
                       record_found);
                error_total++;
            end
            if (record_offset !== want.offset)
            begin
                $error("record_offset mismatch: expected %0h, got %0h", want.offset,
                       record_offset);
                error_total++;
            end
            if (comment_bytes !== want.comment)
            begin
                $error("comment_bytes mismatch: expected %0h, got %0h", want.comment,
                       comment_bytes);
                error_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start = '0;
            region_stop  = '0;
            clear_stream();
            predicted_records.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_STOP)
                    region_stop = pwdata;
                else
                    region_start = pwdata;
            end
            if (in_valid && !in_stall)
                shift_in_byte(data_byte, final_byte);
            if (out_valid && !out_stall)
                check_result();
            outstanding <= predicted_records.size();
        end
    end

endmodule

[tb/testbench.sv]
// top of the zip end record locator bench: clock, reset, register writes and byte stimulus
// depends on zerl_pkg, zip_end_record_locator_core and zerl_checker

module testbench
    import zerl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] START_ADDR = {REG_START, 2'b00};
    localparam logic [ADDR_W-1:0] STOP_ADDR  = {REG_STOP, 2'b00};
    localparam int HOLD_CYCLES  = 80;
    localparam int TABLE_PHASES = 12;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              final_byte;
    logic              out_valid;
    logic              out_stall;
    logic              record_found;
    logic [31:0]       record_offset;
    logic [15:0]       comment_bytes;
    int                mismatches;
    int                outstanding;

    byte_t       frame_bytes [$];
    logic [31:0] cfg_start;
    logic [31:0] cfg_stop;
    int          bytes_sent    = 0;
    int          frames_sent   = 0;
    int          hold_requests = 0;
    bit          steady_flow   = 1'b0;

    logic [31:0] table_start [TABLE_PHASES] = '{
        32'd0, 32'd10, 32'd30, 32'd30, 32'd80, 32'd0,
        32'd5, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd16
    };
    logic [31:0] table_stop [TABLE_PHASES] = '{
        32'd60, 32'd100, 32'd51, 32'd52, 32'd40, 32'd64,
        32'd72, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd21, 32'd90
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    zip_end_record_locator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_found  (record_found),
        .record_offset (record_offset),
        .comment_bytes (comment_bytes)
    );

    zerl_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_found  (record_found),
        .record_offset (record_offset),
        .comment_bytes (comment_bytes),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int hold_served;

        hold_served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= !steady_flow && ($urandom_range(99) < 26);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input byte_t value, input logic last);
        while (!steady_flow && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic fill_noise(input int len);
        frame_bytes.delete();
        repeat (len)
            frame_bytes.push_back(byte_t'($urandom_range(255)));
    endtask

    task automatic plant_signature(input int at);
        frame_bytes[at]     = EOCD_SIGNATURE[7:0];
        frame_bytes[at + 1] = EOCD_SIGNATURE[15:8];
        frame_bytes[at + 2] = EOCD_SIGNATURE[23:16];
        frame_bytes[at + 3] = EOCD_SIGNATURE[31:24];
    endtask

    task automatic plant_record(input int at, input logic [15:0] comment);
        if (at + REC_LEN <= frame_bytes.size())
        begin
            plant_signature(at);
            frame_bytes[at + COMMENT_AT]     = comment[7:0];
            frame_bytes[at + COMMENT_AT + 1] = comment[15:8];
        end
    endtask

    // mostly buffers that hold records aimed at the current region, the rest
    // short buffers and plain noise
    task automatic random_frame();
        int          kind;
        int          len;
        int          at;
        logic [31:0] lo;
        logic [15:0] comment;

        kind = $urandom_range(99);
        if (kind < 60 && cfg_stop >= REC_LEN && cfg_stop <= 400)
        begin
            fill_noise(cfg_stop + $urandom_range(12));
            repeat ($urandom_range(3, 1))
            begin
                lo = (cfg_start <= cfg_stop - REC_LEN && $urandom_range(3) != 0) ?
                     cfg_start : 0;
                at = $urandom_range(cfg_stop - REC_LEN, lo);
                comment = 16'(cfg_stop - at - REC_LEN);
                // now and then a record whose comment length is off
                if ($urandom_range(7) == 0)
                    comment ^= 16'h1 << $urandom_range(15);
                plant_record(at, comment);
            end
        end
        else if (kind < 80)
        begin
            len = (cfg_stop >= 2 && cfg_stop <= 400) ? $urandom_range(cfg_stop - 1, 1) :
                  $urandom_range(60, 1);
            fill_noise(len);
            if (len >= REC_LEN)
            begin
                at = $urandom_range(len - REC_LEN);
                plant_record(at, 16'(cfg_stop - at - REC_LEN));
            end
        end
        else
        begin
            len = $urandom_range(80, 1);
            fill_noise(len);
            if (len >= SIG_LEN && $urandom_range(1) == 1)
                plant_signature($urandom_range(len - SIG_LEN));
        end
    endtask

    // pause the byte stream until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [31:0] start, input logic [31:0] stop,
                             input int frames);
        settle();
        write_register(START_ADDR, start);
        write_register(STOP_ADDR, stop);
        cfg_start = start;
        cfg_stop  = stop;
        repeat (frames)
        begin
            random_frame();
            send_frame();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        final_byte = 1'b0;
        cfg_start  = '0;
        cfg_stop   = '0;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset region: single-byte buffers, nothing can be found
        frame_bytes = '{8'h00};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();

        // smallest region that holds a record, record filling the whole buffer
        settle();
        write_register(START_ADDR, 32'd0);
        write_register(STOP_ADDR, REC_LEN);
        cfg_start = 32'd0;
        cfg_stop  = REC_LEN;
        fill_noise(REC_LEN);
        plant_record(0, 16'h0000);
        send_frame();

        // results held off while tiny buffers keep arriving, so the input backs up
        hold_requests <= hold_requests + 1;
        repeat (24)
        begin
            fill_noise($urandom_range(3, 1));
            send_frame();
        end

        for (int p = 0; p < TABLE_PHASES; p++)
        begin
            // one stretch with neither side idling
            steady_flow <= (p == 5);
            run_phase(table_start[p], table_stop[p], (p == 5) ? 2 : 1);
        end
        steady_flow <= 1'b0;

        // a few regions picked at random
        while (bytes_sent < 500 || frames_sent < 42)
            run_phase($urandom_range(60), $urandom_range(100), 1);

        settle();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
